### rtl/core/fcpc_pkg.sv
// ----------------------------------------------------------------------------
// fcpc_pkg
// Shared types, register codes and the bytewise crc step for the flash chunk
// programmer.
// ----------------------------------------------------------------------------
package fcpc_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_BANK0_BASE = 2'd0;
	localparam logic [1:0] REG_BANK1_BASE = 2'd1;
	localparam logic [1:0] REG_BANK_SIZE  = 2'd2;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [7:0]  PAD_BYTE = 8'hFF;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;

	// kind of work handed from the front to the back
	typedef enum logic [1:0] {
		OP_START,
		OP_DATA,
		OP_REJECT
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic        load_seed;
		logic [31:0] seed;
		logic [7:0]  data;
		logic        last;
		logic [31:0] start_addr;
	} op_t;

	typedef struct packed {
		logic [31:0] bank0_base;
		logic [31:0] bank1_base;
		logic [20:0] bank_size;
	} cfg_t;

	// one byte of reflected crc-32, eight shift steps
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### rtl/core/fcpc_if.sv
// ----------------------------------------------------------------------------
// fcpc_if
// Valid/ready channels for chunk bytes in and program results out.
// ----------------------------------------------------------------------------
interface fcpc_in_if;
	logic        valid;
	logic        ready;
	logic        first_byte;
	logic [1:0]  bank_sel;
	logic [19:0] chunk_offset;
	logic [12:0] chunk_length;
	logic [7:0]  payload_byte;
	logic        load_seed;
	logic [31:0] crc_seed;

	modport source (
		output valid, first_byte, bank_sel, chunk_offset, chunk_length, payload_byte,
		output load_seed, crc_seed,
		input  ready
	);
	modport sink (
		input  valid, first_byte, bank_sel, chunk_offset, chunk_length, payload_byte,
		input  load_seed, crc_seed,
		output ready
	);
endinterface

interface fcpc_out_if;
	logic        valid;
	logic        ready;
	logic        program_valid;
	logic [31:0] prog_address;
	logic [15:0] prog_halfword;
	logic        chunk_done;
	logic        chunk_status;
	logic [31:0] crc_out;

	modport source (
		output valid, program_valid, prog_address, prog_halfword, chunk_done,
		output chunk_status, crc_out,
		input  ready
	);
	modport sink (
		input  valid, program_valid, prog_address, prog_halfword, chunk_done,
		input  chunk_status, crc_out,
		output ready
	);
endinterface

### rtl/core/fcpc_queue.sv
// ----------------------------------------------------------------------------
// fcpc_queue
// Short first-in first-out queue of classified work between front and back.
// ----------------------------------------------------------------------------
module fcpc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  fcpc_pkg::op_t   push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output fcpc_pkg::op_t   pop_data
);

	fcpc_pkg::op_t                      entry_q [fcpc_pkg::QUEUE_DEPTH];
	logic [fcpc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [fcpc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [fcpc_pkg::QUEUE_PTR_W:0]     count_q;
	logic                               do_push;
	logic                               do_pop;

	assign push_ready = (count_q != (fcpc_pkg::QUEUE_PTR_W+1)'(fcpc_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/fcpc_front.sv
// ----------------------------------------------------------------------------
// fcpc_front
// Accepts chunk bytes, checks headers against the bank registers, tracks the
// chunk byte count and hands classified work to the queue.
// ----------------------------------------------------------------------------
module fcpc_front #(
	parameter int MAX_CHUNK_BYTES = 4096,
	parameter int MAX_BANK_BYTES  = 1048576
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fcpc_pkg::cfg_t  cfg,
	fcpc_in_if.sink         in,
	output logic            op_valid,
	input  logic            op_ready,
	output fcpc_pkg::op_t   op
);

	logic        in_chunk_q;
	logic        rejected_q;
	logic [12:0] left_q;

	logic        accept;
	logic [31:0] base;
	logic [31:0] size_ext;
	logic [31:0] limit;
	logic [31:0] span;
	logic        hdr_ok;
	logic [12:0] len_m1;
	logic [12:0] left_dec;
	logic        in_chunk_d;
	logic        rejected_d;
	logic [12:0] left_d;

	assign in.ready = op_ready;
	assign accept   = in.valid && in.ready;

	// header check
	assign base     = in.bank_sel[0] ? cfg.bank1_base : cfg.bank0_base;
	assign size_ext = {11'd0, cfg.bank_size};
	assign limit    = (size_ext > 32'(MAX_BANK_BYTES)) ? 32'(MAX_BANK_BYTES) : size_ext;
	assign span     = {12'd0, in.chunk_offset} + {19'd0, in.chunk_length};
	assign hdr_ok   = !in.bank_sel[1] && (base != '0) && (in.chunk_length != '0) &&
	                  ({19'd0, in.chunk_length} <= 32'(MAX_CHUNK_BYTES)) && (span <= limit);
	assign len_m1   = in.chunk_length - 13'd1;
	assign left_dec = (left_q != '0) ? (left_q - 13'd1) : '0;

	// classification and next chunk state
	always_comb begin
		in_chunk_d     = in_chunk_q;
		rejected_d     = rejected_q;
		left_d         = left_q;
		op_valid       = 1'b0;
		op.kind        = fcpc_pkg::OP_DATA;
		op.load_seed   = 1'b0;
		op.seed        = in.crc_seed;
		op.data        = in.payload_byte;
		op.last        = 1'b0;
		op.start_addr  = base + {12'd0, in.chunk_offset};
		if (in.first_byte) begin
			op_valid     = in.valid;
			op.kind      = hdr_ok ? fcpc_pkg::OP_START : fcpc_pkg::OP_REJECT;
			op.load_seed = in.load_seed;
			op.last      = hdr_ok && (in.chunk_length == 13'd1);
			left_d       = (in.chunk_length != '0) ? len_m1 : '0;
			in_chunk_d   = (in.chunk_length > 13'd1);
			rejected_d   = !hdr_ok;
		end else if (in_chunk_q && rejected_q) begin
			left_d = left_dec;
			if (left_dec == '0) begin
				in_chunk_d = 1'b0;
				rejected_d = 1'b0;
			end
		end else if (in_chunk_q) begin
			op_valid   = in.valid;
			left_d     = left_dec;
			op.last    = (left_dec == '0);
			in_chunk_d = (left_dec != '0);
		end
	end

	// chunk tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_chunk_q <= 1'b0;
			rejected_q <= 1'b0;
			left_q     <= '0;
		end else if (accept) begin
			in_chunk_q <= in_chunk_d;
			rejected_q <= rejected_d;
			left_q     <= left_d;
		end
	end

endmodule

### rtl/core/fcpc_back.sv
// ----------------------------------------------------------------------------
// fcpc_back
// Runs the crc, packs bytes into halfword program commands and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module fcpc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	output logic            op_ready,
	input  fcpc_pkg::op_t   op,
	fcpc_out_if.source      out
);

	logic [31:0] crc_q;
	logic        have_low_q;
	logic [7:0]  held_q;
	logic [31:0] next_addr_q;

	logic        out_valid_q;
	logic        pv_q;
	logic [31:0] paddr_q;
	logic [15:0] hw_q;
	logic        done_q;
	logic        status_q;
	logic [31:0] crc_out_q;

	logic [31:0] crc_base;
	logic [31:0] crc_new;
	logic        have;
	logic [31:0] addr;
	logic        res;
	logic        res_pv;
	logic [31:0] res_addr;
	logic [15:0] res_hw;
	logic        res_done;
	logic        res_status;
	logic [31:0] crc_d;
	logic        have_d;
	logic [7:0]  held_d;
	logic [31:0] addr_d;
	logic        slot_free;
	logic        pop;

	assign crc_base = ((op.kind != fcpc_pkg::OP_DATA) && op.load_seed) ? ~op.seed : crc_q;
	assign crc_new  = fcpc_pkg::crc_byte(crc_base, op.data);
	assign have     = (op.kind == fcpc_pkg::OP_DATA) ? have_low_q : 1'b0;
	assign addr     = (op.kind == fcpc_pkg::OP_DATA) ? next_addr_q : op.start_addr;

	// execute one piece of work
	always_comb begin
		res        = 1'b0;
		res_pv     = 1'b0;
		res_addr   = '0;
		res_hw     = '0;
		res_done   = 1'b0;
		res_status = 1'b0;
		crc_d      = crc_new;
		have_d     = 1'b0;
		held_d     = held_q;
		addr_d     = addr;
		case (op.kind)
			fcpc_pkg::OP_REJECT: begin
				res        = 1'b1;
				res_done   = 1'b1;
				res_status = 1'b1;
				crc_d      = crc_base;
				addr_d     = next_addr_q;
			end
			fcpc_pkg::OP_START, fcpc_pkg::OP_DATA: begin
				if (!have && !op.last) begin
					held_d = op.data;
					have_d = 1'b1;
				end else begin
					res      = 1'b1;
					res_pv   = 1'b1;
					res_addr = addr;
					res_hw   = have ? {op.data, held_q} : {fcpc_pkg::PAD_BYTE, op.data};
					res_done = op.last;
					addr_d   = addr + 32'd2;
				end
			end
			default: begin
				crc_d  = crc_q;
				have_d = have_low_q;
				addr_d = next_addr_q;
			end
		endcase
	end

	assign slot_free = !out_valid_q || out.ready;
	assign op_ready  = !res || slot_free;
	assign pop       = op_valid && op_ready;

	// running crc, packing state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '1;
			have_low_q  <= 1'b0;
			held_q      <= '0;
			next_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				crc_q       <= crc_d;
				have_low_q  <= have_d;
				held_q      <= held_d;
				next_addr_q <= addr_d;
			end
			if (pop && res) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && res) begin
			pv_q      <= res_pv;
			paddr_q   <= res_addr;
			hw_q      <= res_hw;
			done_q    <= res_done;
			status_q  <= res_status;
			crc_out_q <= ~crc_d;
		end
	end

	assign out.valid         = out_valid_q;
	assign out.program_valid = pv_q;
	assign out.prog_address  = paddr_q;
	assign out.prog_halfword = hw_q;
	assign out.chunk_done    = done_q;
	assign out.chunk_status  = status_q;
	assign out.crc_out       = crc_out_q;

`ifndef SYNTH
	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q |-> !pv_q && done_q && (paddr_q == '0) && (hw_q == '0))
		else $error("rejected chunk result carries command fields");
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (pv_q || status_q))
		else $error("result is neither a command nor an error");
	a_hold_low: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (op.kind == fcpc_pkg::OP_DATA) && !have_low_q && !op.last |=> have_low_q)
		else $error("low byte of a halfword not held");
`endif

endmodule

### rtl/core/flash_chunk_program_crc_unit.sv
// ----------------------------------------------------------------------------
// flash_chunk_program_crc_unit
// Firmware chunk programmer: header range check, halfword program commands
// and a running reflected crc-32, with an apb register port.
// ----------------------------------------------------------------------------
// The unit takes one chunk byte per clock cycle while the work queue has room;
// the bytewise crc step and the halfword packing in the back unit are both
// combinational, so a byte can follow in every cycle. The work behind a result
// is registered first in the work queue and then in the output register.
// Header bytes are checked in the front unit, and a four-entry queue lets
// input and output stall independently.
// Bank registers must only be written while no transaction is in flight.
module flash_chunk_program_crc_unit #(
	parameter int MAX_CHUNK_BYTES = 4096,
	parameter int MAX_BANK_BYTES  = 1048576
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	fcpc_in_if.sink     in,
	fcpc_out_if.source  out
);

	fcpc_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic           q_push_valid;
	logic           q_push_ready;
	fcpc_pkg::op_t  q_push_data;
	logic           q_pop_valid;
	logic           q_pop_ready;
	fcpc_pkg::op_t  q_pop_data;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				fcpc_pkg::REG_BANK0_BASE: cfg_q.bank0_base <= pwdata;
				fcpc_pkg::REG_BANK1_BASE: cfg_q.bank1_base <= pwdata;
				fcpc_pkg::REG_BANK_SIZE:  cfg_q.bank_size  <= pwdata[20:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr[3:2])
			fcpc_pkg::REG_BANK0_BASE: prdata = cfg_q.bank0_base;
			fcpc_pkg::REG_BANK1_BASE: prdata = cfg_q.bank1_base;
			fcpc_pkg::REG_BANK_SIZE:  prdata = {11'd0, cfg_q.bank_size};
			default:                  prdata = '0;
		endcase
	end

	fcpc_front #(
		.MAX_CHUNK_BYTES(MAX_CHUNK_BYTES),
		.MAX_BANK_BYTES (MAX_BANK_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in       (in),
		.op_valid (q_push_valid),
		.op_ready (q_push_ready),
		.op       (q_push_data)
	);

	fcpc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	fcpc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_pop_valid),
		.op_ready (q_pop_ready),
		.op       (q_pop_data),
		.out      (out)
	);

endmodule

### verif/chunk_program_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunk_program_checker
// Watches the byte and result channels and the register port of the flash
// chunk programmer, predicts every program command and reject with its own
// copy of the range check, halfword packing and crc-32, and compares them
// field by field against what the unit delivers.
// ----------------------------------------------------------------------------
module chunk_program_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	fcpc_in_if          in_mon,
	fcpc_out_if         out_mon,
	output int          mismatch_count,
	output int          pending_count,
	output int          result_count,
	output int          program_count,
	output int          reject_count
);

	localparam int          CHUNK_LIMIT     = 4096;
	localparam logic [31:0] BANK_LIMIT      = 32'd1048576;
	localparam logic [31:0] CRC32_REFLECTED = 32'hEDB88320;
	localparam logic [7:0]  PAD_FILL        = 8'hFF;
	localparam logic        STATUS_OK       = 1'b0;
	localparam logic        STATUS_REJECTED = 1'b1;
	localparam int          PRINT_CAP       = 100;

	typedef struct packed {
		logic        program_valid;
		logic [31:0] address;
		logic [15:0] halfword;
		logic        done;
		logic        status;
		logic [31:0] crc;
	} chunk_result_t;

	chunk_result_t expected_results[$];

	// register mirror
	logic [31:0] base0;
	logic [31:0] base1;
	logic [20:0] size_reg;

	// predicted chunk state
	logic [31:0] crc_run;
	logic        chunk_open;
	logic        dropping;
	logic [12:0] remaining;
	logic [31:0] addr_next;
	logic [7:0]  low_byte;
	logic        low_valid;

	int errors;
	int results;
	int programs;
	int rejects;

	// reflected crc-32, one data bit per step
	function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		logic        fb;
		r = c;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ d[i];
			r  = {1'b0, r[31:1]} ^ (fb ? CRC32_REFLECTED : 32'd0);
		end
		return r;
	endfunction

	task automatic push_result(input logic pv, input logic [31:0] addr,
			input logic [15:0] hw, input logic done, input logic status);
		chunk_result_t r;
		r.program_valid = pv;
		r.address       = addr;
		r.halfword      = hw;
		r.done          = done;
		r.status        = status;
		r.crc           = ~crc_run;
		expected_results.push_back(r);
	endtask

	// advance the predicted state by one accepted byte
	task automatic predict_byte();
		logic [31:0] base;
		logic [31:0] limit;
		logic [12:0] len;
		logic [7:0]  data;
		logic        ok;
		len  = in_mon.chunk_length;
		data = in_mon.payload_byte;
		if (in_mon.first_byte) begin
			base  = (in_mon.bank_sel == 2'd0) ? base0 : base1;
			limit = ({11'd0, size_reg} > BANK_LIMIT) ? BANK_LIMIT : {11'd0, size_reg};
			if (in_mon.load_seed) begin
				crc_run = ~in_mon.crc_seed;
			end
			low_valid = 1'b0;
			low_byte  = 8'd0;
			ok = (in_mon.bank_sel <= 2'd1) && (base != 32'd0) && (len != 13'd0)
				&& (len <= CHUNK_LIMIT)
				&& (({12'd0, in_mon.chunk_offset} + {19'd0, len}) <= limit);
			if (!ok) begin
				chunk_open = (len > 13'd1);
				dropping   = 1'b1;
				remaining  = (len != 13'd0) ? len - 13'd1 : 13'd0;
				addr_next  = 32'd0;
				push_result(1'b0, 32'd0, 16'd0, 1'b1, STATUS_REJECTED);
				return;
			end
			chunk_open = 1'b1;
			dropping   = 1'b0;
			remaining  = len;
			addr_next  = base + {12'd0, in_mon.chunk_offset};
		end else if (!chunk_open) begin
			return;
		end else if (dropping) begin
			// tail of a rejected chunk is swallowed
			if (remaining != 13'd0) begin
				remaining = remaining - 13'd1;
			end
			if (remaining == 13'd0) begin
				chunk_open = 1'b0;
				dropping   = 1'b0;
			end
			return;
		end

		crc_run = crc_fold(crc_run, data);
		if (remaining != 13'd0) begin
			remaining = remaining - 13'd1;
		end

		if (!low_valid) begin
			if (remaining == 13'd0) begin
				// odd final byte, high half padded
				chunk_open = 1'b0;
				push_result(1'b1, addr_next, {PAD_FILL, data}, 1'b1, STATUS_OK);
				addr_next = addr_next + 32'd2;
			end else begin
				low_byte  = data;
				low_valid = 1'b1;
			end
		end else begin
			push_result(1'b1, addr_next, {data, low_byte}, remaining == 13'd0, STATUS_OK);
			addr_next = addr_next + 32'd2;
			low_valid = 1'b0;
			low_byte  = 8'd0;
			if (remaining == 13'd0) begin
				chunk_open = 1'b0;
			end
		end
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < PRINT_CAP) begin
			$display("%0t mismatch in %s: got %h, expected %h", $realtime, field, got, want);
		end
		errors++;
	endtask

	task automatic check_result();
		chunk_result_t w;
		if (expected_results.size() == 0) begin
			report_mismatch("result with nothing outstanding", out_mon.prog_address, 32'd0);
			return;
		end
		w = expected_results.pop_front();
		results++;
		if (w.program_valid) begin
			programs++;
		end
		if (w.status == STATUS_REJECTED) begin
			rejects++;
		end
		if (out_mon.program_valid !== w.program_valid) begin
			report_mismatch("program_valid", 32'(out_mon.program_valid),
				32'(w.program_valid));
		end
		if (out_mon.prog_address !== w.address) begin
			report_mismatch("prog_address", out_mon.prog_address, w.address);
		end
		if (out_mon.prog_halfword !== w.halfword) begin
			report_mismatch("prog_halfword", 32'(out_mon.prog_halfword), 32'(w.halfword));
		end
		if (out_mon.chunk_done !== w.done) begin
			report_mismatch("chunk_done", 32'(out_mon.chunk_done), 32'(w.done));
		end
		if (out_mon.chunk_status !== w.status) begin
			report_mismatch("chunk_status", 32'(out_mon.chunk_status), 32'(w.status));
		end
		if (out_mon.crc_out !== w.crc) begin
			report_mismatch("crc_out", out_mon.crc_out, w.crc);
		end
	endtask

	// results first, then the byte taken at the same edge, then register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			base0      = 32'd0;
			base1      = 32'd0;
			size_reg   = 21'd0;
			crc_run    = 32'hFFFF_FFFF;
			chunk_open = 1'b0;
			dropping   = 1'b0;
			remaining  = 13'd0;
			addr_next  = 32'd0;
			low_byte   = 8'd0;
			low_valid  = 1'b0;
			errors     = 0;
			results    = 0;
			programs   = 0;
			rejects    = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				check_result();
			end
			if (in_mon.valid && in_mon.ready) begin
				predict_byte();
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					fcpc_pkg::REG_BANK0_BASE: base0 = pwdata;
					fcpc_pkg::REG_BANK1_BASE: base1 = pwdata;
					fcpc_pkg::REG_BANK_SIZE:  size_reg = pwdata[20:0];
					default: ;
				endcase
			end
		end
		mismatch_count <= errors;
		pending_count  <= expected_results.size();
		result_count   <= results;
		program_count  <= programs;
		reject_count   <= rejects;
	end

endmodule

### verif/tb_flash_chunk_program_crc_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_flash_chunk_program_crc_unit
// Drives firmware chunks into the flash chunk programmer across several bank
// settings: a directed set of edge cases, then random chunks with abandoned
// and rejected ones mixed in, under changing sender and receiver stalls.
// The checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_flash_chunk_program_crc_unit;

	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 16;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	fcpc_in_if  in_ch ();
	fcpc_out_if out_ch ();

	int src_idle_pct;
	int sink_idle_pct;
	int bytes_sent;
	int chunks_sent;
	int settings_used;
	int quiet_cycles;

	int mismatch_count;
	int pending_count;
	int result_count;
	int program_count;
	int reject_count;

	logic [20:0] cur_size;

	flash_chunk_program_crc_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in      (in_ch),
		.out     (out_ch)
	);

	chunk_program_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.in_mon         (in_ch),
		.out_mon        (out_ch),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.result_count   (result_count),
		.program_count  (program_count),
		.reject_count   (reject_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_ch.ready = arst_n && ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || psel || (in_ch.valid && in_ch.ready)
				|| (out_ch.valid && out_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("no transaction for %0d cycles, %0d results outstanding",
				quiet_cycles, pending_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [7:0] pick_data();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// called and returns at a falling edge
	task automatic send_byte(input logic first, input logic [1:0] bank,
			input logic [19:0] offset, input logic [12:0] length, input logic [7:0] data,
			input logic seed_on, input logic [31:0] seed);
		while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid        = 1'b1;
		in_ch.first_byte   = first;
		in_ch.bank_sel     = bank;
		in_ch.chunk_offset = offset;
		in_ch.chunk_length = length;
		in_ch.payload_byte = data;
		in_ch.load_seed    = seed_on;
		in_ch.crc_seed     = seed;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// header on the first byte, junk header fields on the rest
	task automatic send_chunk(input logic [1:0] bank, input logic [19:0] offset,
			input logic [12:0] length, input logic seed_on, input logic [31:0] seed,
			input int nbytes);
		send_byte(1'b1, bank, offset, length, pick_data(), seed_on, seed);
		for (int i = 1; i < nbytes; i++) begin
			send_byte(1'b0, 2'($urandom), 20'($urandom), 13'($urandom), pick_data(),
				1'($urandom), $urandom);
		end
		chunks_sent++;
	endtask

	task automatic wait_drained();
		in_ch.valid = 1'b0;
		do @(posedge clk); while (pending_count != 0);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// only once the unit has gone quiet
	task automatic configure(input logic [31:0] b0, input logic [31:0] b1,
			input logic [20:0] size);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		write_reg(fcpc_pkg::REG_BANK0_BASE, b0);
		write_reg(fcpc_pkg::REG_BANK1_BASE, b1);
		write_reg(fcpc_pkg::REG_BANK_SIZE, {11'd0, size});
		cur_size = size;
		settings_used++;
	endtask

	// mostly well-formed chunks, some rejected, truncated or preceded by noise
	task automatic random_chunk();
		logic [1:0] bank;
		int limit;
		int len;
		int off;
		int nbytes;
		int sel;
		if ($urandom_range(0, 39) == 0) begin
			wait_drained();
		end
		if ($urandom_range(0, 19) == 0) begin
			send_byte(1'b0, 2'($urandom), 20'($urandom), 13'($urandom), pick_data(),
				1'($urandom), $urandom);
		end
		bank = ($urandom_range(0, 99) < 92) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
		sel = $urandom_range(0, 99);
		if (sel < 80) begin
			len = $urandom_range(1, 12);
		end else if (sel < 90) begin
			len = $urandom_range(13, 80);
		end else if (sel < 94) begin
			len = 0;
		end else if (sel < 97) begin
			len = $urandom_range(4097, 8191);
		end else begin
			len = $urandom_range(81, 300);
		end
		limit = (cur_size > 21'd1048576) ? 1048576 : int'(cur_size);
		sel = $urandom_range(0, 9);
		if (sel < 2 && limit >= len && len <= 1048576) begin
			off = limit - len;
			if (off > 1048575) begin
				off = 1048575;
			end
		end else if (sel < 8 && limit >= len) begin
			off = $urandom_range(0, (limit - len > 1048575) ? 1048575 : limit - len);
		end else begin
			off = $urandom_range(0, 1048575);
		end
		if (len == 0) begin
			nbytes = 1;
		end else if (len > 4096) begin
			nbytes = $urandom_range(1, 4);
		end else if ($urandom_range(0, 9) == 0) begin
			nbytes = $urandom_range(1, len);
		end else begin
			nbytes = len;
		end
		send_chunk(bank, 20'(off), 13'(len), $urandom_range(0, 7) == 0, $urandom, nbytes);
	endtask

	task automatic run_phase(input int src_pct, input int sink_pct, input logic [31:0] b0,
			input logic [31:0] b1, input logic [20:0] size, input int budget);
		int start;
		configure(b0, b1, size);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			random_chunk();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = 4'd0;
		pwdata        = 32'd0;
		in_ch.valid        = 1'b0;
		in_ch.first_byte   = 1'b0;
		in_ch.bank_sel     = 2'd0;
		in_ch.chunk_offset = 20'd0;
		in_ch.chunk_length = 13'd0;
		in_ch.payload_byte = 8'd0;
		in_ch.load_seed    = 1'b0;
		in_ch.crc_seed     = 32'd0;
		out_ch.ready  = 1'b0;
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		bytes_sent    = 0;
		chunks_sent   = 0;
		settings_used = 0;
		quiet_cycles  = 0;
		cur_size      = 21'd0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed edge cases; bank one sits just below the top of the address space
		configure(32'h0800_0000, 32'hFFFF_FFF0, 21'd1048576);
		send_byte(1'b0, 2'd0, 20'd0, 13'd0, 8'h5A, 1'b0, 32'd0);     // stray byte, no chunk open
		send_chunk(2'd0, 20'd0, 13'd1, 1'b1, 32'h0000_0000, 1);      // single padded byte
		send_chunk(2'd0, 20'hFFFFE, 13'd2, 1'b0, 32'd0, 2);          // ends exactly at bank end
		send_chunk(2'd0, 20'hFFFFF, 13'd2, 1'b0, 32'd0, 2);          // one byte past bank end
		send_chunk(2'd2, 20'd0, 13'd1, 1'b1, 32'hFFFF_FFFF, 1);      // bad bank, seed still taken
		send_chunk(2'd3, 20'd0, 13'd3, 1'b0, 32'd0, 3);              // bad bank, tail dropped
		send_chunk(2'd0, 20'd0, 13'd0, 1'b0, 32'd0, 1);              // zero length
		send_byte(1'b0, 2'd1, 20'd7, 13'd5, 8'hFF, 1'b1, 32'd1);     // stray after zero length
		send_chunk(2'd1, 20'd14, 13'd3, 1'b0, 32'd0, 3);             // address wraps to zero
		send_chunk(2'd0, 20'd100, 13'd4, 1'b0, 32'd0, 3);            // abandoned with a held byte
		send_chunk(2'd0, 20'd200, 13'd2, 1'b0, 32'd0, 2);
		send_chunk(2'd0, 20'd0, 13'd4097, 1'b0, 32'd0, 1);           // overlong, cut short
		send_chunk(2'd1, 20'd0, 13'd4096, 1'b1, $urandom, 2);        // longest chunk, abandoned

		// random phases: sender light / receiver heavy, the reverse, then none
		run_phase(7, 68, $urandom_range(1, 32'hFFFF_FFFF), 32'd0, 21'h1F_FFFF, 450);
		run_phase(68, 7, 32'hFFFF_FFFF, $urandom_range(1, 32'hFFFF_FFFF),
			21'($urandom_range(1, 4096)), 450);
		run_phase(0, 0, $urandom_range(1, 32'hFFFF_FFFF), $urandom_range(1, 32'hFFFF_FFFF),
			21'd0, 60);
		run_phase(0, 0, 32'h0000_0001, $urandom_range(1, 32'hFFFF_FFFF), 21'd1048576, 300);
		// full chunk ending exactly at the bank end
		send_chunk(2'd0, 20'(1048576 - 64), 13'd64, 1'b1, $urandom, 64);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d bytes in %0d chunks over %0d register settings",
			bytes_sent, chunks_sent, settings_used);
		$display("checked %0d results: %0d program commands, %0d rejects",
			result_count, program_count, reject_count);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/fcpc_pkg.sv
rtl/core/fcpc_if.sv
rtl/core/fcpc_queue.sv
rtl/core/fcpc_front.sv
rtl/core/fcpc_back.sv
rtl/core/flash_chunk_program_crc_unit.sv
verif/chunk_program_checker.sv
verif/tb_flash_chunk_program_crc_unit.sv
